### src/tasdf_pkg.sv
// tasdf_pkg: shared constants, types and helper functions for the tar stream deframer
// no dependencies; used by every module of the block but tasdf_in_stage
package tasdf_pkg;

  localparam int BLOCK_BYTES      = 512;
  localparam int NAME_BYTES       = 100;
  localparam int SIZE_BITS_DEF    = 36;
  localparam int SIZE_FIELD_START = 124;
  localparam int SIZE_FIELD_LEN   = 12;
  localparam int PAX_LEN          = 10;
  localparam int OFFSET_W         = $clog2(BLOCK_BYTES);
  localparam int PAX_CNT_W        = $clog2(PAX_LEN + 1);
  localparam int FILE_SIZE_W      = 36;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_DATA,
    MODE_SKIP,
    MODE_ENDED
  } mode_t;

  typedef enum logic [1:0] {
    OCT_LEAD,
    OCT_DIGITS,
    OCT_TRAIL,
    OCT_DONE
  } oct_phase_t;

  typedef enum logic [2:0] {
    KIND_SKIP   = 3'd0,
    KIND_HDR    = 3'd1,
    KIND_ACCEPT = 3'd2,
    KIND_REJECT = 3'd3,
    KIND_DATA   = 3'd4,
    KIND_END    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0]             data;
    kind_t                  kind;
    logic                   name_valid;
    logic [FILE_SIZE_W-1:0] file_size;
    logic                   last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

  // characters of the pax header marker "PaxHeader/"
  function automatic logic [7:0] pax_char(input logic [PAX_CNT_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "P";
      4'd1:    c = "a";
      4'd2:    c = "x";
      4'd3:    c = "H";
      4'd4:    c = "e";
      4'd5:    c = "a";
      4'd6:    c = "d";
      4'd7:    c = "e";
      4'd8:    c = "r";
      4'd9:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/tasdf_in_stage.sv
// tasdf_in_stage: input register of the deframer, one byte deep
// depends on nothing; the result stage supplies the advance signal
module tasdf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       step,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       load;

  assign step     = s1_valid_r && advance;
  assign load     = !s1_valid_r || advance;
  assign in_stall = !load;
  assign s1_byte  = s1_byte_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

endmodule

### src/tasdf_parse.sv
// tasdf_parse: header collection, size parsing and data/skip tracking for one byte per step
// depends on tasdf_pkg
module tasdf_parse #(
  parameter int SIZE_BITS = tasdf_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          in_data,
  output tasdf_pkg::result_t  res
);

  localparam int OW = tasdf_pkg::OFFSET_W;
  localparam int PW = tasdf_pkg::PAX_CNT_W;

  tasdf_pkg::mode_t      mode_r,       mode_nxt;
  logic [OW-1:0]         offset_r,     offset_nxt;
  logic                  name_ended_r, name_ended_nxt;
  logic                  name_empty_r, name_empty_nxt;
  logic [PW-1:0]         pax_cnt_r,    pax_cnt_nxt;
  logic                  pax_found_r,  pax_found_nxt;
  logic                  all_blank_r,  all_blank_nxt;
  tasdf_pkg::oct_phase_t oct_phase_r,  oct_phase_nxt;
  logic                  oct_bad_r,    oct_bad_nxt;
  logic [SIZE_BITS-1:0]  accum_r,      accum_nxt;
  logic [SIZE_BITS-1:0]  remain_r,     remain_nxt;
  logic [OW-1:0]         pad_r,        pad_nxt;

  logic                  ws;
  logic                  digit;
  logic                  in_name;
  logic                  in_size;
  logic                  hdr_end;
  logic                  acc_ovf;
  logic [SIZE_BITS-1:0]  acc_shift;
  logic [SIZE_BITS-1:0]  size_fin;
  logic [OW-1:0]         pad_fin;
  logic [SIZE_BITS-1:0]  remain_dec;
  logic [PW-1:0]         pax_cnt_try;

  assign ws        = tasdf_pkg::is_ws(in_data);
  assign digit     = (in_data >= "0") && (in_data <= "7");
  assign in_name   = offset_r < OW'(tasdf_pkg::NAME_BYTES);
  assign in_size   = (offset_r >= OW'(tasdf_pkg::SIZE_FIELD_START)) &&
                     (offset_r < OW'(tasdf_pkg::SIZE_FIELD_START + tasdf_pkg::SIZE_FIELD_LEN));
  assign hdr_end   = offset_r == OW'(tasdf_pkg::BLOCK_BYTES - 1);
  // a shift by three saturates exactly when any of the top three bits is set
  assign acc_ovf   = accum_r[SIZE_BITS-1 -: 3] != 3'd0;
  assign acc_shift = {accum_r[SIZE_BITS-4:0], in_data[2:0]};
  assign size_fin  = (oct_bad_r || oct_phase_r == tasdf_pkg::OCT_LEAD) ? '0 : accum_r;
  // padding up to the block boundary
  assign pad_fin   = OW'(0) - size_fin[OW-1:0];
  assign remain_dec = (remain_r != '0) ? remain_r - SIZE_BITS'(1) : remain_r;
  assign pax_cnt_try = (in_data == tasdf_pkg::pax_char(pax_cnt_r)) ? pax_cnt_r + PW'(1) :
                       (in_data == "P") ? PW'(1) : PW'(0);

  always_comb begin
    mode_nxt       = mode_r;
    offset_nxt     = offset_r;
    name_ended_nxt = name_ended_r;
    name_empty_nxt = name_empty_r;
    pax_cnt_nxt    = pax_cnt_r;
    pax_found_nxt  = pax_found_r;
    all_blank_nxt  = all_blank_r;
    oct_phase_nxt  = oct_phase_r;
    oct_bad_nxt    = oct_bad_r;
    accum_nxt      = accum_r;
    remain_nxt     = remain_r;
    pad_nxt        = pad_r;

    res            = '0;
    res.data       = in_data;
    res.kind       = tasdf_pkg::KIND_SKIP;

    case (mode_r)
      tasdf_pkg::MODE_ENDED: begin
        res.kind = tasdf_pkg::KIND_END;
      end
      tasdf_pkg::MODE_DATA: begin
        res.kind   = tasdf_pkg::KIND_DATA;
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          res.last = 1'b1;
          mode_nxt = (pad_r != '0) ? tasdf_pkg::MODE_SKIP : tasdf_pkg::MODE_HEADER;
        end
      end
      tasdf_pkg::MODE_SKIP: begin
        res.kind = tasdf_pkg::KIND_SKIP;
        if (remain_r != '0) begin
          remain_nxt = remain_dec;
        end else if (pad_r != '0) begin
          pad_nxt = pad_r - OW'(1);
        end
        if (remain_nxt == '0 && pad_nxt == '0) begin
          mode_nxt = tasdf_pkg::MODE_HEADER;
        end
      end
      default: begin
        res.kind = tasdf_pkg::KIND_HDR;
        if (!ws) begin
          all_blank_nxt = 1'b0;
        end

        if (in_name && !name_ended_r) begin
          if (in_data == 8'h00) begin
            name_ended_nxt = 1'b1;
            if (offset_r == '0) begin
              name_empty_nxt = 1'b1;
            end
          end else begin
            res.name_valid = 1'b1;
            if (!pax_found_r) begin
              if (pax_cnt_try == PW'(tasdf_pkg::PAX_LEN)) begin
                pax_found_nxt = 1'b1;
                pax_cnt_nxt   = '0;
              end else begin
                pax_cnt_nxt = pax_cnt_try;
              end
            end
          end
        end

        if (in_size) begin
          case (oct_phase_r)
            tasdf_pkg::OCT_LEAD: begin
              if (!ws) begin
                if (digit) begin
                  accum_nxt     = SIZE_BITS'(in_data[2:0]);
                  oct_phase_nxt = tasdf_pkg::OCT_DIGITS;
                end else begin
                  oct_bad_nxt   = 1'b1;
                  oct_phase_nxt = tasdf_pkg::OCT_DONE;
                end
              end
            end
            tasdf_pkg::OCT_DIGITS: begin
              if (digit) begin
                accum_nxt = acc_ovf ? '1 : acc_shift;
              end else if (ws) begin
                oct_phase_nxt = tasdf_pkg::OCT_TRAIL;
              end else if (in_data == 8'h00) begin
                oct_phase_nxt = tasdf_pkg::OCT_DONE;
              end else begin
                oct_bad_nxt   = 1'b1;
                oct_phase_nxt = tasdf_pkg::OCT_DONE;
              end
            end
            tasdf_pkg::OCT_TRAIL: begin
              if (!ws) begin
                if (in_data != 8'h00) begin
                  oct_bad_nxt = 1'b1;
                end
                oct_phase_nxt = tasdf_pkg::OCT_DONE;
              end
            end
            default: begin
            end
          endcase
        end

        if (hdr_end) begin
          res.file_size = tasdf_pkg::FILE_SIZE_W'(size_fin);
          if (all_blank_nxt) begin
            res.kind = tasdf_pkg::KIND_END;
            mode_nxt = tasdf_pkg::MODE_ENDED;
          end else if (name_empty_r) begin
            res.kind = tasdf_pkg::KIND_REJECT;
          end else if (pax_found_r) begin
            // pax extension: skip its payload and padding
            res.kind   = tasdf_pkg::KIND_REJECT;
            remain_nxt = size_fin;
            pad_nxt    = pad_fin;
            if (size_fin != '0) begin
              mode_nxt = tasdf_pkg::MODE_SKIP;
            end
          end else if (size_fin != '0) begin
            res.kind   = tasdf_pkg::KIND_ACCEPT;
            remain_nxt = size_fin;
            pad_nxt    = pad_fin;
            mode_nxt   = tasdf_pkg::MODE_DATA;
          end else begin
            res.kind = tasdf_pkg::KIND_REJECT;
          end
          offset_nxt     = '0;
          name_ended_nxt = 1'b0;
          name_empty_nxt = 1'b0;
          pax_cnt_nxt    = '0;
          pax_found_nxt  = 1'b0;
          all_blank_nxt  = 1'b1;
          oct_phase_nxt  = tasdf_pkg::OCT_LEAD;
          oct_bad_nxt    = 1'b0;
          accum_nxt      = '0;
        end else begin
          offset_nxt = offset_r + OW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= tasdf_pkg::MODE_HEADER;
      offset_r     <= '0;
      name_ended_r <= 1'b0;
      name_empty_r <= 1'b0;
      pax_cnt_r    <= '0;
      pax_found_r  <= 1'b0;
      all_blank_r  <= 1'b1;
      oct_phase_r  <= tasdf_pkg::OCT_LEAD;
      oct_bad_r    <= 1'b0;
      accum_r      <= '0;
      remain_r     <= '0;
      pad_r        <= '0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      offset_r     <= offset_nxt;
      name_ended_r <= name_ended_nxt;
      name_empty_r <= name_empty_nxt;
      pax_cnt_r    <= pax_cnt_nxt;
      pax_found_r  <= pax_found_nxt;
      all_blank_r  <= all_blank_nxt;
      oct_phase_r  <= oct_phase_nxt;
      oct_bad_r    <= oct_bad_nxt;
      accum_r      <= accum_nxt;
      remain_r     <= remain_nxt;
      pad_r        <= pad_nxt;
    end
  end

endmodule

### src/tasdf_out_stage.sv
// tasdf_out_stage: result register of the deframer, holds one item against stall
// depends on tasdf_pkg
module tasdf_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  tasdf_pkg::result_t                res,
  output logic                              advance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic [2:0]                        out_kind,
  output logic                              out_name_byte_valid,
  output logic [tasdf_pkg::FILE_SIZE_W-1:0] out_file_size,
  output logic                              out_last_data
);

  logic               valid_r;
  logic               valid_nxt;
  tasdf_pkg::result_t res_r;

  // room when empty or when the held item leaves this cycle
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_byte            = res_r.data;
  assign out_kind            = res_r.kind;
  assign out_name_byte_valid = res_r.name_valid;
  assign out_file_size       = res_r.file_size;
  assign out_last_data       = res_r.last;

endmodule

### src/tar_archive_stream_deframer_top.sv
// path: an accepted byte is held in the byte register, and its item then in the result register
// throughput: one byte per cycle while out_stall is low; the byte register and the result register
//   advance together, so while a result waits a new byte is taken only into an empty byte register
// reset: synchronous active-low rst_n empties both registers and returns the
//   parser to header collection at offset zero, with no clearing pass
module tar_archive_stream_deframer_top #(
  parameter int SIZE_BITS = tasdf_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic [2:0]                        out_kind,
  output logic                              out_name_byte_valid,
  output logic [tasdf_pkg::FILE_SIZE_W-1:0] out_file_size,
  output logic                              out_last_data
);

  logic               advance;
  logic               step;
  logic [7:0]         s1_byte;
  tasdf_pkg::result_t res;

  tasdf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .advance  (advance),
    .step     (step),
    .s1_byte  (s1_byte)
  );

  tasdf_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_data (s1_byte),
    .res     (res)
  );

  tasdf_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step                (step),
    .res                 (res),
    .advance             (advance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_name_byte_valid (out_name_byte_valid),
    .out_file_size       (out_file_size),
    .out_last_data       (out_last_data)
  );

endmodule

### src/tasdf_checker.sv
// tasdf_checker: port-level assertions for the tar stream deframer, bound to the top level
// depends on tasdf_pkg and tar_archive_stream_deframer_top
module tasdf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [7:0]                        out_byte,
  input logic [2:0]                        out_kind,
  input logic                              out_name_byte_valid,
  input logic [tasdf_pkg::FILE_SIZE_W-1:0] out_file_size,
  input logic                              out_last_data
);

  logic ended_r;
  logic ended_nxt;

  always_comb begin
    ended_nxt = ended_r;
    if (out_valid && !out_stall && out_kind == tasdf_pkg::KIND_END) begin
      ended_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
    end else begin
      ended_r <= ended_nxt;
    end
  end

  // a held item keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind) &&
      $stable(out_file_size))
    else $error("result item changed while stalled");

  // once the archive has ended every later item says so
  assert property (@(posedge clk) disable iff (!rst_n)
    ended_r && out_valid |-> out_kind == tasdf_pkg::KIND_END)
    else $error("item after end of archive not marked as ended");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_data |-> out_kind == tasdf_pkg::KIND_DATA)
    else $error("last data flag outside file data");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_name_byte_valid |-> out_kind == tasdf_pkg::KIND_HDR && out_byte != 8'h00)
    else $error("name tag on a byte that cannot be a name character");

  // a size only shows on the item that closes a header
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_file_size != '0 |->
      out_kind == tasdf_pkg::KIND_ACCEPT || out_kind == tasdf_pkg::KIND_REJECT ||
      out_kind == tasdf_pkg::KIND_END)
    else $error("file size reported outside a header end");

endmodule

bind tar_archive_stream_deframer_top tasdf_checker u_tasdf_checker (.*);

### dv/tasdf_deframe_checker.sv
// tasdf_deframe_checker: watches the byte and result channels of the tar stream deframer,
// predicts every result from the accepted bytes and compares them in order
// depends on tasdf_pkg for the mode, phase and kind enums and the result struct
`timescale 1ns / 100ps

module tasdf_deframe_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        in_byte,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [7:0]                        out_byte,
  input  logic [2:0]                        out_kind,
  input  logic                              out_name_byte_valid,
  input  logic [tasdf_pkg::FILE_SIZE_W-1:0] out_file_size,
  input  logic                              out_last_data,
  output int                                fail_count,
  output int                                outstanding
);

  localparam int                              ACC_W    = tasdf_pkg::FILE_SIZE_W + 4;
  localparam logic [ACC_W-1:0]                SIZE_SAT = {4'd0, {tasdf_pkg::FILE_SIZE_W{1'b1}}};
  localparam logic [8*tasdf_pkg::PAX_LEN-1:0] PAX_MARK = "PaxHeader/";

  // parser state
  tasdf_pkg::mode_t                  mode_q;
  int unsigned                       hdr_pos;
  bit                                name_done;
  bit                                name_blank;
  int unsigned                       mark_cnt;
  bit                                mark_seen;
  bit                                block_blank;
  tasdf_pkg::oct_phase_t             oct_ph;
  bit                                oct_bad;
  logic [ACC_W-1:0]                  size_acc;
  logic [tasdf_pkg::FILE_SIZE_W-1:0] body_left;
  int unsigned                       pad_left;

  tasdf_pkg::result_t deframed_q[$];
  int                 errs = 0;
  int                 n_seen = 0;

  function automatic bit ws_char(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic clear_block();
    hdr_pos     = 0;
    name_done   = 1'b0;
    name_blank  = 1'b0;
    mark_cnt    = 0;
    mark_seen   = 1'b0;
    block_blank = 1'b1;
    oct_ph      = tasdf_pkg::OCT_LEAD;
    oct_bad     = 1'b0;
    size_acc    = '0;
  endtask

  task automatic scan_size_byte(input logic [7:0] b);
    bit digit;
    digit = (b >= "0" && b <= "7");
    case (oct_ph)
      tasdf_pkg::OCT_LEAD: begin
        if (!ws_char(b)) begin
          if (digit) begin
            size_acc = ACC_W'(b - "0");
            oct_ph   = tasdf_pkg::OCT_DIGITS;
          end else begin
            oct_bad = 1'b1;
            oct_ph  = tasdf_pkg::OCT_DONE;
          end
        end
      end
      tasdf_pkg::OCT_DIGITS: begin
        if (digit) begin
          // saturate rather than wrap
          if (size_acc > (SIZE_SAT >> 3)) begin
            size_acc = SIZE_SAT;
          end else begin
            size_acc = (size_acc << 3) + ACC_W'(b - "0");
            if (size_acc > SIZE_SAT) size_acc = SIZE_SAT;
          end
        end else if (ws_char(b)) begin
          oct_ph = tasdf_pkg::OCT_TRAIL;
        end else if (b == 8'h00) begin
          oct_ph = tasdf_pkg::OCT_DONE;
        end else begin
          oct_bad = 1'b1;
          oct_ph  = tasdf_pkg::OCT_DONE;
        end
      end
      tasdf_pkg::OCT_TRAIL: begin
        if (!ws_char(b)) begin
          if (b != 8'h00) oct_bad = 1'b1;
          oct_ph = tasdf_pkg::OCT_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic deframe_byte(input logic [7:0] b, output tasdf_pkg::result_t r);
    logic [tasdf_pkg::FILE_SIZE_W-1:0] sz;
    int unsigned                       pad;
    r      = '0;
    r.data = b;
    r.kind = tasdf_pkg::KIND_SKIP;
    case (mode_q)
      tasdf_pkg::MODE_ENDED: r.kind = tasdf_pkg::KIND_END;
      tasdf_pkg::MODE_DATA: begin
        r.kind = tasdf_pkg::KIND_DATA;
        if (body_left != 0) body_left--;
        if (body_left == 0) begin
          r.last = 1'b1;
          mode_q = (pad_left != 0) ? tasdf_pkg::MODE_SKIP : tasdf_pkg::MODE_HEADER;
        end
      end
      tasdf_pkg::MODE_SKIP: begin
        if (body_left != 0) body_left--;
        else if (pad_left != 0) pad_left--;
        if (body_left == 0 && pad_left == 0) mode_q = tasdf_pkg::MODE_HEADER;
      end
      default: begin
        r.kind = tasdf_pkg::KIND_HDR;
        if (!ws_char(b)) block_blank = 1'b0;
        if (hdr_pos < tasdf_pkg::NAME_BYTES && !name_done) begin
          if (b == 8'h00) begin
            name_done = 1'b1;
            if (hdr_pos == 0) name_blank = 1'b1;
          end else begin
            r.name_valid = 1'b1;
            if (!mark_seen) begin
              // a mismatch may still start a fresh marker
              if (mark_cnt < tasdf_pkg::PAX_LEN &&
                  b == PAX_MARK[8*(tasdf_pkg::PAX_LEN-1-mark_cnt) +: 8])
                mark_cnt++;
              else
                mark_cnt = (b == "P") ? 1 : 0;
              if (mark_cnt >= tasdf_pkg::PAX_LEN) begin
                mark_seen = 1'b1;
                mark_cnt  = 0;
              end
            end
          end
        end
        if (hdr_pos >= tasdf_pkg::SIZE_FIELD_START &&
            hdr_pos < tasdf_pkg::SIZE_FIELD_START + tasdf_pkg::SIZE_FIELD_LEN)
          scan_size_byte(b);
        if (hdr_pos >= tasdf_pkg::BLOCK_BYTES - 1) begin
          sz  = (oct_bad || oct_ph == tasdf_pkg::OCT_LEAD) ? '0 :
                size_acc[tasdf_pkg::FILE_SIZE_W-1:0];
          pad = (sz[tasdf_pkg::OFFSET_W-1:0] == '0) ? 0 :
                tasdf_pkg::BLOCK_BYTES - int'(sz[tasdf_pkg::OFFSET_W-1:0]);
          r.file_size = sz;
          if (block_blank) begin
            r.kind = tasdf_pkg::KIND_END;
            mode_q = tasdf_pkg::MODE_ENDED;
          end else if (name_blank) begin
            r.kind = tasdf_pkg::KIND_REJECT;
          end else if (mark_seen) begin
            r.kind    = tasdf_pkg::KIND_REJECT;
            body_left = sz;
            pad_left  = pad;
            if (sz != 0 || pad != 0) mode_q = tasdf_pkg::MODE_SKIP;
          end else if (sz != 0) begin
            r.kind    = tasdf_pkg::KIND_ACCEPT;
            body_left = sz;
            pad_left  = pad;
            mode_q    = tasdf_pkg::MODE_DATA;
          end else begin
            r.kind = tasdf_pkg::KIND_REJECT;
          end
          clear_block();
        end else begin
          hdr_pos++;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    tasdf_pkg::result_t want;
    if (!rst_n) begin
      mode_q    = tasdf_pkg::MODE_HEADER;
      body_left = '0;
      pad_left  = 0;
      clear_block();
      deframed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("result %0d: none expected, got byte %02h kind %0d", n_seen,
                     out_byte, out_kind);
        end else begin
          want = deframed_q.pop_front();
          if (out_byte !== want.data || out_kind !== want.kind ||
              out_name_byte_valid !== want.name_valid ||
              out_file_size !== want.file_size || out_last_data !== want.last) begin
            errs++;
            if (errs <= 10)
              $display({"result %0d: expected byte %02h kind %0d name %0b size %0d last %0b,",
                        " got byte %02h kind %0d name %0b size %0d last %0b"},
                       n_seen, want.data, want.kind, want.name_valid, want.file_size,
                       want.last, out_byte, out_kind, out_name_byte_valid, out_file_size,
                       out_last_data);
          end
        end
        n_seen++;
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, want);
        deframed_q.insert(deframed_q.size(), want);
      end
    end
    fail_count  <= errs;
    outstanding <= deframed_q.size();
  end

endmodule

### dv/tb.sv
// tb: drives tar archive streams into the deframer with random idling on both sides
// depends on tasdf_pkg, tar_archive_stream_deframer_top and tasdf_deframe_checker
`timescale 1ns / 100ps

module tb;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [7:0]                        in_byte;
  logic                              out_valid;
  logic                              out_stall;
  logic [7:0]                        out_byte;
  logic [2:0]                        out_kind;
  logic                              out_name_byte_valid;
  logic [tasdf_pkg::FILE_SIZE_W-1:0] out_file_size;
  logic                              out_last_data;
  int                                fail_count;
  int                                outstanding;

  logic [7:0] hdr [tasdf_pkg::BLOCK_BYTES];
  bit         tx_quiet;

  always #10 clk = ~clk;

  tar_archive_stream_deframer_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_name_byte_valid (out_name_byte_valid),
    .out_file_size       (out_file_size),
    .out_last_data       (out_last_data)
  );

  tasdf_deframe_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_kind            (out_kind),
    .out_name_byte_valid (out_name_byte_valid),
    .out_file_size       (out_file_size),
    .out_last_data       (out_last_data),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(8, 13);
    return (k == 8) ? 8'd32 : 8'(k);
  endfunction

  function automatic longint unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 40);
    if (r < 92) return $urandom_range(41, 600);
    return $urandom_range(601, 1600);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_header();
    for (int i = 0; i < tasdf_pkg::BLOCK_BYTES; i++) hdr[i] = 8'($urandom);
  endtask

  task automatic put_text(input int at, input string s);
    for (int k = 0; k < s.len(); k++) hdr[at+k] = s[k];
  endtask

  task automatic put_random_name(input int len);
    for (int k = 0; k < len; k++) hdr[k] = 8'($urandom_range(1, 255));
    if (len < tasdf_pkg::NAME_BYTES) hdr[len] = 8'h00;
  endtask

  // unused tail of the field is nul
  task automatic put_size_field(input string s);
    for (int k = 0; k < tasdf_pkg::SIZE_FIELD_LEN; k++)
      hdr[tasdf_pkg::SIZE_FIELD_START+k] = (k < s.len()) ? s[k] : 8'h00;
  endtask

  // octal size in one of the legal layouts
  task automatic put_size(input longint unsigned sz);
    string ds;
    int    lead;
    int    pos;
    int    term;
    ds   = ($urandom_range(0, 2) == 0) ? $sformatf("%011o", sz) : $sformatf("%0o", sz);
    lead = $urandom_range(0, 2);
    if (lead + ds.len() > tasdf_pkg::SIZE_FIELD_LEN) lead = 0;
    term = $urandom_range(0, 2);
    pos  = tasdf_pkg::SIZE_FIELD_START;
    put_size_field("");
    for (int k = 0; k < lead; k++) hdr[pos++] = blank_char();
    for (int k = 0; k < ds.len(); k++) hdr[pos++] = ds[k];
    if (term == 1 && pos < tasdf_pkg::SIZE_FIELD_START + tasdf_pkg::SIZE_FIELD_LEN)
      hdr[pos++] = blank_char();
    while (term == 2 && pos < tasdf_pkg::SIZE_FIELD_START + tasdf_pkg::SIZE_FIELD_LEN)
      hdr[pos++] = blank_char();
  endtask

  // header block, then the body and its padding up to the block boundary
  task automatic send_entry(input longint unsigned body);
    longint unsigned total;
    for (int i = 0; i < tasdf_pkg::BLOCK_BYTES; i++) push_byte(hdr[i]);
    total = body;
    if (body % tasdf_pkg::BLOCK_BYTES != 0)
      total = body + tasdf_pkg::BLOCK_BYTES - body % tasdf_pkg::BLOCK_BYTES;
    for (longint unsigned i = 0; i < total; i++) push_byte(8'($urandom));
  endtask

  // receiver
  initial begin : receiver
    int gap;
    int taken;
    bit quiet;
    out_stall <= 1'b0;
    taken = 0;
    quiet = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 256 == 0) quiet = $urandom_range(0, 1);
      gap = quiet ? 0 : $urandom_range(0, 10);
      // long hold so the input side backs up
      if (taken == 300) gap = 400;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int              r;
    int              len;
    longint unsigned sz;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    tx_quiet = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one header of a random flavour, its body within one block
    tx_quiet = $urandom_range(0, 1);
    r  = $urandom_range(0, 99);
    sz = 0;
    random_header();
    if (r < 35) begin
      put_random_name($urandom_range(1, tasdf_pkg::NAME_BYTES));
      sz = $urandom_range(1, tasdf_pkg::BLOCK_BYTES);
      put_size(sz);
    end else if (r < 50) begin
      len = $urandom_range(tasdf_pkg::PAX_LEN, tasdf_pkg::NAME_BYTES);
      put_random_name(len);
      put_text($urandom_range(0, len - tasdf_pkg::PAX_LEN), "PaxHeader/");
      sz = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, tasdf_pkg::BLOCK_BYTES);
      put_size(sz);
    end else if (r < 58) begin
      put_random_name($urandom_range(1, tasdf_pkg::NAME_BYTES));
      put_size(0);
    end else if (r < 66) begin
      // empty name, possibly with the largest size
      hdr[0] = 8'h00;
      if ($urandom_range(0, 1) == 0) put_size_field("777777777777");
      else put_size(pick_size());
    end else if (r < 82) begin
      put_random_name($urandom_range(1, tasdf_pkg::NAME_BYTES));
      case ($urandom_range(0, 5))
        0: put_size_field("17 x");
        1: put_size_field("8");
        2: put_size_field(" 12a");
        3: put_size_field("            ");
        4: begin
          put_size_field({" \011", "17 \015\012"});
          sz = 15;
        end
        default: begin
          // twelve digits with no terminator
          put_size_field("000000000021");
          sz = 17;
        end
      endcase
    end else if (r < 90) begin
      // random block whose size field cannot parse
      hdr[tasdf_pkg::SIZE_FIELD_START] = "9";
    end else begin
      for (int i = 0; i < tasdf_pkg::BLOCK_BYTES; i++) hdr[i] = 8'h00;
    end
    send_entry(sz);

    tx_quiet = $urandom_range(0, 1);
    if (sz == 0) begin
      // end of archive, the bytes after it are only passed on
      for (int i = 0; i < tasdf_pkg::BLOCK_BYTES; i++) hdr[i] = blank_char();
      send_entry(0);
    end
    repeat (20) push_byte(8'($urandom));
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
